// ===== src/lcu8_pkg.sv =====
// Shared types, constants and code-point helpers of the charset transcoder.
package lcu8_pkg;

    // Encoding modes held in the mode register.
    typedef enum logic [1:0] {
        MODE_STRICT  = 2'd0,
        MODE_WIN1252 = 2'd1,
        MODE_LATIN1  = 2'd2,
        MODE_RAW     = 2'd3
    } mode_t;

    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int MAX_BYTES = 3;

    // UTF-8 limits used by the strict checker.
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_CLASS1 = 21'h000080;
    localparam logic [20:0] CP_MIN_CLASS2 = 21'h000800;
    localparam logic [20:0] CP_MIN_CLASS3 = 21'h010000;

    // One classified input item, ready to be serialized.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                count;
        logic                      eos;
        logic                      verdict;
    } entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Windows-1252 code points of bytes 0x80 to 0x9F.
    function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:    cp = 16'h20AC;
            5'd1:    cp = 16'h0081;
            5'd2:    cp = 16'h201A;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201E;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02C6;
            5'd9:    cp = 16'h2030;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd13:   cp = 16'h008D;
            5'd14:   cp = 16'h017D;
            5'd15:   cp = 16'h008F;
            5'd16:   cp = 16'h0090;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201C;
            5'd20:   cp = 16'h201D;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02DC;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203A;
            5'd28:   cp = 16'h0153;
            5'd29:   cp = 16'h009D;
            5'd30:   cp = 16'h017E;
            default: cp = 16'h0178;
        endcase
        return cp;
    endfunction

endpackage

// ===== src/lcu8_front.sv =====
// Front end: mode register, item classification, UTF-8 encoding and strict checking.
module lcu8_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  lcu8_pkg::q_status_t q_status,
    output logic                push,
    output lcu8_pkg::entry_t    push_entry
);
    import lcu8_pkg::*;

    mode_t       mode_reg;
    logic [1:0]  cont_reg,  cont_next;
    logic [20:0] acc_reg,   acc_next;
    logic [1:0]  class_reg, class_next;
    logic        err_reg,   err_next;

    logic        accept;
    logic [15:0] cp;
    logic [20:0] min_cp;
    logic [1:0]  cont_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~q_status.full;
    assign accept    = s_tvalid & s_tready;
    assign push      = accept;

    // Code point of the byte in the two encoding modes.
    always_comb
    begin
        if (mode_reg == MODE_WIN1252 && s_tdata[7:5] == 3'b100)
        begin
            cp = cp1252_high(s_tdata[4:0]);
        end
        else
        begin
            cp = {8'h00, s_tdata};
        end
    end

    // Strict UTF-8 checker, next state for this byte.
    always_comb
    begin
        cont_next  = cont_reg;
        acc_next   = acc_reg;
        class_next = class_reg;
        err_next   = err_reg;
        cont_dec   = cont_reg - 2'd1;
        case (class_reg)
            2'd1:    min_cp = CP_MIN_CLASS1;
            2'd2:    min_cp = CP_MIN_CLASS2;
            default: min_cp = CP_MIN_CLASS3;
        endcase
        if (!err_reg)
        begin
            if (cont_reg != 2'd0)
            begin
                if (s_tdata[7:6] != 2'b10)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    acc_next  = {acc_reg[14:0], s_tdata[5:0]};
                    cont_next = cont_dec;
                    if (cont_dec == 2'd0)
                    begin
                        if (acc_next < min_cp || acc_next > CP_MAX ||
                            (acc_next >= CP_SURR_LO && acc_next <= CP_SURR_HI))
                        begin
                            err_next = 1'b1;
                        end
                    end
                end
            end
            else if (s_tdata[7])
            begin
                if (s_tdata[7:5] == 3'b110)
                begin
                    class_next = 2'd1;
                    cont_next  = 2'd1;
                    acc_next   = {16'h0000, s_tdata[4:0]};
                end
                else if (s_tdata[7:4] == 4'b1110)
                begin
                    class_next = 2'd2;
                    cont_next  = 2'd2;
                    acc_next   = {17'h00000, s_tdata[3:0]};
                end
                else if (s_tdata[7:3] == 5'b11110)
                begin
                    class_next = 2'd3;
                    cont_next  = 2'd3;
                    acc_next   = {18'h00000, s_tdata[2:0]};
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    // Output bytes and count of the classified item.
    always_comb
    begin
        push_entry.bytes   = '0;
        push_entry.eos     = s_tlast;
        push_entry.verdict = 1'b0;
        if (mode_reg == MODE_WIN1252 || mode_reg == MODE_LATIN1)
        begin
            if (cp < 16'h0080)
            begin
                push_entry.count    = 2'd1;
                push_entry.bytes[0] = cp[7:0];
            end
            else if (cp < 16'h0800)
            begin
                push_entry.count    = 2'd2;
                push_entry.bytes[0] = {3'b110, cp[10:6]};
                push_entry.bytes[1] = {2'b10, cp[5:0]};
            end
            else
            begin
                push_entry.count    = 2'd3;
                push_entry.bytes[0] = {4'b1110, cp[15:12]};
                push_entry.bytes[1] = {2'b10, cp[11:6]};
                push_entry.bytes[2] = {2'b10, cp[5:0]};
            end
        end
        else
        begin
            push_entry.count    = 2'd1;
            push_entry.bytes[0] = s_tdata;
            if (mode_reg == MODE_STRICT)
            begin
                push_entry.verdict = s_tlast & (err_next | (cont_next != 2'd0));
            end
        end
    end

    // Mode register and checker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_WIN1252;
            cont_reg  <= 2'd0;
            acc_reg   <= '0;
            class_reg <= 2'd0;
            err_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= mode_t'(cfg_data);
            end
            if (accept)
            begin
                if (s_tlast)
                begin
                    cont_reg  <= 2'd0;
                    acc_reg   <= '0;
                    class_reg <= 2'd0;
                    err_reg   <= 1'b0;
                end
                else if (mode_reg == MODE_STRICT)
                begin
                    cont_reg  <= cont_next;
                    acc_reg   <= acc_next;
                    class_reg <= class_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

endmodule

// ===== src/lcu8_queue.sv =====
// Short queue of classified items between the front and the back.
module lcu8_queue
#(
    parameter int DEPTH = lcu8_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcu8_pkg::entry_t    push_entry,
    input  logic                pop,
    output lcu8_pkg::entry_t    head,
    output lcu8_pkg::q_status_t status
);
    import lcu8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [LW-1:0] FULL_LVL = LW'(DEPTH);

    entry_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [LW-1:0] level_reg;

    assign status.full  = (level_reg == FULL_LVL);
    assign status.empty = (level_reg == '0);
    assign head         = mem[rd_ptr_reg];

    // Storage, written at the tail.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + LW'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - LW'(1);
            end
        end
    end

endmodule

// ===== src/lcu8_back.sv =====
// Back end: serializes each queued item into output bytes through an output register.
module lcu8_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  lcu8_pkg::entry_t    head,
    input  lcu8_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);
    import lcu8_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       done_reg;
    logic [1:0] user_reg;
    logic       advance;
    logic       load;
    logic       last;

    assign advance = ~valid_reg | m_tready;
    assign load    = advance & ~q_status.empty;
    assign last    = (idx_reg == head.count - 2'd1);
    assign pop     = load & last;

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = done_reg;
    assign m_tuser  = user_reg;

    // Byte index within the head item and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= ~q_status.empty;
            if (load)
            begin
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= head.bytes[idx_reg];
            done_reg    <= last & head.eos;
            user_reg[0] <= last;
            user_reg[1] <= last & head.eos & head.verdict;
        end
    end

endmodule

// ===== src/legacy_charset_to_utf8_transcoder_top.sv =====
// Top level of the legacy charset to UTF-8 transcoder.
//
// The input stream carries one source byte per item in s_tdata, with s_tlast
// marking the last byte of a string. The output stream carries one byte per
// item in m_tdata; m_tlast marks the final byte of a string, m_tuser[0] the
// final byte caused by one input item, and m_tuser[1] the strict-mode verdict
// (1 means the string is invalid UTF-8 and is to be discarded).
// The cfg channel writes the two-bit encoding mode: 0 strict UTF-8 check,
// 1 Windows-1252, 2 Latin-1, 3 raw. The user sees that it is written only while
// the block is idle; the block does not enforce this. The front classifies and
// encodes an item in the cycle it is accepted and writes it to a queue; the
// back emits its bytes through the output register, one byte per cycle while
// the receiver is ready, so an item gives one to three bytes: one in raw and
// strict modes, up to three for high Windows-1252 bytes. Input is taken back
// to back as long as the queue has room; when the receiver stalls, the output
// register holds and the queue fills, then s_tready falls. Reset empties the
// queue, clears the checker and sets the mode to Windows-1252.
module legacy_charset_to_utf8_transcoder_top
#(
    parameter int QUEUE_DEPTH = lcu8_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,    // encoding_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // in_byte
    input  logic       s_tlast,     // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic       m_tlast,     // string_done
    output logic [1:0] m_tuser      // [0] last_of_run, [1] utf8_error
);
    import lcu8_pkg::*;

    logic      push;
    logic      pop;
    entry_t    push_entry;
    entry_t    head;
    q_status_t q_status;

    lcu8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    lcu8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    lcu8_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An error verdict only travels on the final byte of a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("utf8 error flagged off the end of a string");

    // The end of a string is always the end of an item's bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("string end without end of run");

    // The queue is never read while empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // Nothing is accepted while the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("queue written while full");

endmodule

// ===== tb/sv/lcu8_transcoder_checker.sv =====
// Checker of the charset transcoder: predicts every output byte and compares it.
module lcu8_transcoder_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic [1:0] m_tuser,
    output int         fail_count,
    output int         pending,
    output int         items_seen,
    output int         bytes_seen,
    output int         invalid_strings
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcu8_pkg::*;

    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] MIN_FOUR    = 21'h010000;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] UNI_TOP     = 21'h10FFFF;

    // Code points of Windows-1252 bytes 0x80 to 0x9F, first entry leftmost.
    localparam logic [0:31][15:0] WIN_HIGH_CP = {
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    // One output byte with its flags.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
        logic       bad_utf8;
    } out_byte_t;

    out_byte_t   due_bytes[$];
    mode_t       mode;
    logic [1:0]  cont_left;
    logic [20:0] cp_acc;
    logic [1:0]  seq_class;
    logic        err_seen;
    int          mismatches;
    int          n_items;
    int          n_bytes;
    int          n_invalid;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic push_byte(input logic [7:0] data, input logic run_end, input logic eos,
                             input logic verdict);
        out_byte_t ob;
        ob.data     = data;
        ob.run_end  = run_end;
        ob.str_end  = run_end & eos;
        ob.bad_utf8 = run_end & eos & verdict;
        if (ob.bad_utf8)
            n_invalid++;
        due_bytes.insert(due_bytes.size(), ob);
    endtask

    // UTF-8 form of a code point of the basic plane.
    task automatic push_code_point(input logic [15:0] cp, input logic eos);
        if (cp < 16'h0080)
            push_byte(cp[7:0], 1'b1, eos, 1'b0);
        else if (cp < 16'h0800)
        begin
            push_byte({3'b110, cp[10:6]}, 1'b0, eos, 1'b0);
            push_byte({2'b10, cp[5:0]}, 1'b1, eos, 1'b0);
        end
        else
        begin
            push_byte({4'b1110, cp[15:12]}, 1'b0, eos, 1'b0);
            push_byte({2'b10, cp[11:6]}, 1'b0, eos, 1'b0);
            push_byte({2'b10, cp[5:0]}, 1'b1, eos, 1'b0);
        end
    endtask

    // Strict checker: once an error is seen the rest of the string goes unchecked.
    task automatic check_strict(input logic [7:0] c);
        logic [20:0] floor_cp;
        if (err_seen)
            return;
        if (cont_left != 2'd0)
        begin
            if (c[7:6] != 2'b10)
            begin
                err_seen = 1'b1;
                return;
            end
            cp_acc    = {cp_acc[14:0], c[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
            begin
                floor_cp = (seq_class == 2'd1) ? MIN_TWO :
                           (seq_class == 2'd2) ? MIN_THREE : MIN_FOUR;
                if (cp_acc < floor_cp || (cp_acc >= SURR_FIRST && cp_acc <= SURR_LAST) ||
                    cp_acc > UNI_TOP)
                    err_seen = 1'b1;
            end
            return;
        end
        if (!c[7])
            return;
        if (c[7:5] == 3'b110)
        begin
            seq_class = 2'd1;
            cp_acc    = {16'd0, c[4:0]};
        end
        else if (c[7:4] == 4'b1110)
        begin
            seq_class = 2'd2;
            cp_acc    = {17'd0, c[3:0]};
        end
        else if (c[7:3] == 5'b11110)
        begin
            seq_class = 2'd3;
            cp_acc    = {18'd0, c[2:0]};
        end
        else
        begin
            err_seen = 1'b1;
            return;
        end
        cont_left = seq_class;
    endtask

    // Work out the output bytes of one input item.
    task automatic transcode_byte(input logic [7:0] b, input logic eos);
        logic verdict;
        verdict = 1'b0;
        case (mode)
            MODE_WIN1252:
                if (b >= 8'h80 && b < 8'hA0)
                    push_code_point(WIN_HIGH_CP[b[4:0]], eos);
                else
                    push_code_point({8'd0, b}, eos);
            MODE_LATIN1:
                push_code_point({8'd0, b}, eos);
            default:
            begin
                if (mode == MODE_STRICT)
                begin
                    check_strict(b);
                    if (eos)
                    begin
                        if (cont_left != 2'd0)
                            err_seen = 1'b1;
                        verdict = err_seen;
                    end
                end
                push_byte(b, 1'b1, eos, verdict);
            end
        endcase
        if (eos)
        begin
            cont_left = 2'd0;
            cp_acc    = 21'd0;
            seq_class = 2'd0;
            err_seen  = 1'b0;
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        out_byte_t want;
        if (!rst_n)
        begin
            due_bytes.delete();
            mode       = MODE_WIN1252;
            cont_left  = 2'd0;
            cp_acc     = 21'd0;
            seq_class  = 2'd0;
            err_seen   = 1'b0;
            mismatches = 0;
            n_items    = 0;
            n_bytes    = 0;
            n_invalid  = 0;
        end
        else
        begin
            // Compare an accepted output byte with the oldest prediction.
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                n_bytes++;
                if (due_bytes.size() == 0)
                    report_mismatch($sformatf("output byte %02h with nothing expected", m_tdata));
                else
                begin
                    want = due_bytes.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_tdata, want.data));
                    if (m_tuser[0] !== want.run_end)
                        report_mismatch($sformatf("last_of_run %b, expected %b (byte %02h)",
                                                  m_tuser[0], want.run_end, want.data));
                    if (m_tlast !== want.str_end)
                        report_mismatch($sformatf("string_done %b, expected %b (byte %02h)",
                                                  m_tlast, want.str_end, want.data));
                    if (m_tuser[1] !== want.bad_utf8)
                        report_mismatch($sformatf("utf8_error %b, expected %b (byte %02h)",
                                                  m_tuser[1], want.bad_utf8, want.data));
                end
            end
            // Predict the bytes of an accepted input item.
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
            begin
                n_items++;
                transcode_byte(s_tdata, s_tlast);
            end
            // Mode register write.
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                mode = mode_t'(cfg_data);
        end
        fail_count      <= mismatches;
        pending         <= due_bytes.size();
        items_seen      <= n_items;
        bytes_seen      <= n_bytes;
        invalid_strings <= n_invalid;
    end

endmodule

// ===== tb/sv/tb_legacy_charset_to_utf8_transcoder_top.sv =====
// Testbench top of the charset transcoder: clock, reset, stimulus and verdict.
module tb_legacy_charset_to_utf8_transcoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcu8_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    int fail_count;
    int pending;
    int items_seen;
    int bytes_seen;
    int invalid_strings;

    mode_t      cur_mode;
    logic [7:0] str_bytes[$];
    int         items_sent;
    int         mode_writes;
    int         cycle_count;
    bit         steady_tx;
    bit         steady_rx;
    bit         hold_request;

    legacy_charset_to_utf8_transcoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    lcu8_transcoder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending         (pending),
        .items_seen      (items_seen),
        .bytes_seen      (bytes_seen),
        .invalid_strings (invalid_strings)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d bytes outstanding", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Receiver: random stalls, and on request one long hold-off.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (steady_rx || $urandom_range(0, 2) != 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(negedge clk);
            end
        end
    end

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = steady_tx ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Wait until every output byte has been taken.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_mode(input mode_t m);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_mode = m;
        mode_writes++;
    endtask

    // Send the built string; in strict mode it may change mode partway through.
    task automatic send_string(input bit may_switch);
        int split;
        split = -1;
        if (may_switch && str_bytes.size() > 1 && $urandom_range(0, 7) == 0)
            split = $urandom_range(1, str_bytes.size() - 1);
        foreach (str_bytes[i])
        begin
            if (i == split)
            begin
                set_mode(mode_t'($urandom_range(1, 3)));
                send_item(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1) == 1)
                    set_mode(MODE_STRICT);
            end
            send_item(str_bytes[i], i == str_bytes.size() - 1);
        end
    endtask

    // Add one byte at the end of the string being built.
    task automatic add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    // Append a code point in a UTF-8 form of the given length, overlong if asked.
    task automatic append_utf8(input logic [20:0] cp, input int len);
        case (len)
            1:
                add_byte({1'b0, cp[6:0]});
            2:
            begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed UTF-8 with random content, plus broken sequences and noise.
    task automatic build_strict_string();
        int          kind;
        int          len;
        logic [20:0] cp;
        logic [7:0]  nb;
        str_bytes.delete();
        repeat ($urandom_range(1, 4))
        begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(2, 4);
            if (kind < 25)
                append_utf8(21'($urandom_range(0, 'h7F)), 1);
            else if (kind < 45)
                append_utf8(21'($urandom_range('h80, 'h7FF)), 2);
            else if (kind < 65)
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= 21'h00D800 && cp <= 21'h00DFFF)
                    cp = cp ^ 21'h004000;
                append_utf8(cp, 3);
            end
            else if (kind < 78)
                append_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
            else if (kind < 83)
            begin
                // Overlong: a value that fits a shorter form.
                cp = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
                     (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                                  21'($urandom_range(0, 'hFFFF));
                append_utf8(cp, len);
            end
            else if (kind < 86)
                append_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
            else if (kind < 89)
                append_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            else if (kind < 93)
            begin
                // Sequence cut short by one byte.
                append_utf8(21'($urandom_range('h80, 'h10FFFF)), len);
                void'(str_bytes.pop_back());
            end
            else if (kind < 97)
            begin
                // A continuation replaced by a byte that is not one.
                append_utf8(21'($urandom_range('h80, 'h10FFFF)), len);
                nb = 8'($urandom_range(0, 255));
                if (nb[7:6] == 2'b10)
                    nb[6] = 1'b1;
                str_bytes[str_bytes.size() - $urandom_range(1, len - 1)] = nb;
            end
            else
                add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Random bytes; in Windows-1252 mode the table range is favored.
    task automatic build_legacy_string();
        logic [7:0] b;
        str_bytes.delete();
        repeat ($urandom_range(1, 6))
        begin
            b = 8'($urandom_range(0, 255));
            if (cur_mode == MODE_WIN1252 && $urandom_range(0, 2) == 0)
                b = 8'($urandom_range('h80, 'h9F));
            add_byte(b);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        int target;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = MODE_WIN1252;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        cur_mode     = MODE_WIN1252;
        items_sent   = 0;
        mode_writes  = 0;
        cycle_count  = 0;
        steady_tx    = 1'b0;
        steady_rx    = 1'b0;
        hold_request = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mode is Windows-1252: ASCII top, euro sign, undefined slot, 0xA0, 0xFF.
        str_bytes = '{8'h7F, 8'h80, 8'h81, 8'hA0, 8'hFF};
        send_string(1'b0);
        set_mode(MODE_LATIN1);
        str_bytes = '{8'h00, 8'hFF};
        send_string(1'b0);
        set_mode(MODE_RAW);
        str_bytes = '{8'h80};
        send_string(1'b0);

        // Strict mode: overlong, surrogate, above the Unicode range, bad lead,
        // cut-short sequence and bad continuation.
        set_mode(MODE_STRICT);
        str_bytes = '{8'hC0, 8'h80};
        send_string(1'b0);
        str_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string(1'b0);
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string(1'b0);
        str_bytes = '{8'hFF};
        send_string(1'b0);
        str_bytes = '{8'hE2, 8'h82};
        send_string(1'b0);
        str_bytes = '{8'hC3, 8'h41};
        send_string(1'b0);

        // Mode change inside a string: the raw byte leaves the checker state alone.
        send_item(8'hE2, 1'b0);
        set_mode(MODE_RAW);
        send_item(8'h41, 1'b0);
        set_mode(MODE_STRICT);
        send_item(8'h82, 1'b0);
        send_item(8'hAC, 1'b1);

        // Receiver holds off while two- and three-byte outputs keep coming in.
        set_mode(MODE_WIN1252);
        @(posedge clk);
        steady_tx    = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
            send_item(8'($urandom_range('h80, 'h9F)), i == 23);
        steady_tx = 1'b0;

        // Random strings in groups, each group begins under one mode; a strict string may change the mode partway.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 40)
                set_mode(MODE_STRICT);
            else
                set_mode(mode_t'($urandom_range(1, 3)));
            @(posedge clk);
            steady_tx = ($urandom_range(0, 4) == 0);
            steady_rx = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 8))
            begin
                if (cur_mode == MODE_STRICT)
                    build_strict_string();
                else
                    build_legacy_string();
                send_string(cur_mode == MODE_STRICT);
            end
        end

        // Drain and give the verdict.
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d bytes under %0d mode writes, got %0d output bytes back;",
                 items_seen, mode_writes, bytes_seen);
        $display("%0d strict strings were flagged invalid, %0d mismatches.",
                 invalid_strings, fail_count);
        if (pending != 0)
            $display("%0d expected output bytes never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/lcu8_pkg.sv
src/lcu8_front.sv
src/lcu8_queue.sv
src/lcu8_back.sv
src/legacy_charset_to_utf8_transcoder_top.sv
tb/sv/lcu8_transcoder_checker.sv
tb/sv/tb_legacy_charset_to_utf8_transcoder_top.sv
